@@ rtl/diag_gated_rnn_cell_forward_defines.svh @@
// Assertion macros used by the pipeline control.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef DIAG_GATED_RNN_CELL_FORWARD_DEFINES_SVH
`define DIAG_GATED_RNN_CELL_FORWARD_DEFINES_SVH
`ifndef SYNTHESIS
`define DRGC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DRGC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) pre |=> post) else $error(msg);
`else
`define DRGC_ASSERT(lbl, prop, msg)
`define DRGC_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

@@ rtl/drgc_pkg.sv @@
`default_nettype none
package drgc_pkg;

  localparam int DataWidth  = 16;
  localparam int FracBits   = 12;
  localparam int TabDepth   = 256;
  localparam int IdxBits    = $clog2(TabDepth);
  localparam int FrBits     = DataWidth - IdxBits;
  localparam int TabValBits = FracBits + 2;
  localparam int DeltaBits  = FracBits + 1;
  localparam int NumStages  = 8;

  localparam longint TabDenom = longint'(TabDepth) << FracBits;
  localparam longint Q30      = longint'(1) << 30;

  typedef enum logic [1:0] {
    FnSigmoid = 2'b01,
    FnTanh    = 2'b10
  } lut_fn_t;

  typedef logic [TabValBits-1:0] tab_t [TabDepth];

  typedef struct packed {
    logic fetch;
    logic blend;
  } lut_ctl_t;

  typedef struct packed {
    logic [NumStages-1:0] load;
    logic                 in_ready;
    logic                 out_valid;
  } pipe_ctl_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] hidden_prev;
    logic signed [DataWidth-1:0] cand_proj;
    logic signed [DataWidth-1:0] delta_proj;
    logic signed [DataWidth-1:0] gate_in;
    logic signed [DataWidth-1:0] recur_gain;
    logic signed [DataWidth-1:0] delta_gain;
    logic signed [DataWidth-1:0] cand_bias;
    logic signed [DataWidth-1:0] delta_bias;
    logic signed [DataWidth-1:0] gate_bias;
  } in_item_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] hidden_new;
    logic signed [DataWidth-1:0] gated_out;
    logic signed [DataWidth-1:0] cand_preact;
    logic        [DeltaBits-1:0] delta_val;
    logic signed [DataWidth-1:0] gate_preact;
  } out_item_t;

  // Restoring division, used only while the constant tables are built.
  function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // exp(-x) for x in [0, 1], both in Q30.
  function automatic longint exp_frac(input longint x);
    longint term;
    longint sum;
    term = Q30;
    sum  = Q30;
    for (int k = 1; k <= 24; k++) begin
      term = longint'(udiv(64'((term * x) >>> 30), 64'(k)));
      sum  = k[0] ? sum - term : sum + term;
    end
    return (sum < 0) ? longint'(0) : sum;
  endfunction

  // round(2^s / (1 + exp(-n / TabDenom))) for n >= 0.
  function automatic longint sig_pos(input longint n, input int s);
    longint q;
    longint r;
    longint f;
    longint e;
    longint em1;
    longint den;
    longint num;
    q = n / TabDenom;
    r = n % TabDenom;
    f = 0;
    e = 0;
    if (q < 40) begin
      for (int k = 0; k < 30; k++) begin
        r = r << 1;
        f = f << 1;
        if (r >= TabDenom) begin
          r = r - TabDenom;
          f = f | longint'(1);
        end
      end
      e   = exp_frac(f);
      em1 = exp_frac(Q30);
      for (longint k = 0; k < q; k++) begin
        e = (e * em1 + (Q30 >>> 1)) >>> 30;
      end
    end
    den = Q30 + e;
    num = (longint'(1) << s) << 30;
    return longint'(udiv(64'(num + (den >>> 1)), 64'(den)));
  endfunction

  function automatic logic [TabValBits-1:0] tab_entry(input int i, input lut_fn_t fn);
    longint off;
    longint n;
    longint v;
    off = (longint'(i) << DataWidth) - (longint'(TabDepth) << (DataWidth - 1));
    n   = (off < 0) ? -off : off;
    if (fn == FnTanh) begin
      v = sig_pos(2 * n, FracBits + 1);
      if (off < 0) v = (longint'(1) << (FracBits + 1)) - v;
    end else begin
      v = sig_pos(n, FracBits);
      if (off < 0) v = (longint'(1) << FracBits) - v;
    end
    return v[TabValBits-1:0];
  endfunction

  function automatic tab_t build_tab(input lut_fn_t fn, input int base);
    tab_t t;
    for (int j = 0; j < TabDepth; j++) begin
      t[j] = tab_entry(j + base, fn);
    end
    return t;
  endfunction

  // Lower and upper neighbor of every interpolation interval.
  localparam tab_t SigLo = build_tab(FnSigmoid, 0);
  localparam tab_t SigHi = build_tab(FnSigmoid, 1);
  localparam tab_t TnhLo = build_tab(FnTanh, 0);
  localparam tab_t TnhHi = build_tab(FnTanh, 1);

endpackage
`default_nettype wire

@@ rtl/drgc_in_if.sv @@
`default_nettype none
interface drgc_in_if import drgc_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [DataWidth-1:0] hidden_prev;
  logic signed [DataWidth-1:0] cand_proj;
  logic signed [DataWidth-1:0] delta_proj;
  logic signed [DataWidth-1:0] gate_in;
  logic signed [DataWidth-1:0] recur_gain;
  logic signed [DataWidth-1:0] delta_gain;
  logic signed [DataWidth-1:0] cand_bias;
  logic signed [DataWidth-1:0] delta_bias;
  logic signed [DataWidth-1:0] gate_bias;

  modport source (
    output valid, hidden_prev, cand_proj, delta_proj, gate_in,
           recur_gain, delta_gain, cand_bias, delta_bias, gate_bias,
    input  ready
  );

  modport sink (
    input  valid, hidden_prev, cand_proj, delta_proj, gate_in,
           recur_gain, delta_gain, cand_bias, delta_bias, gate_bias,
    output ready
  );
endinterface
`default_nettype wire

@@ rtl/drgc_out_if.sv @@
`default_nettype none
interface drgc_out_if import drgc_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [DataWidth-1:0] hidden_new;
  logic signed [DataWidth-1:0] gated_out;
  logic signed [DataWidth-1:0] cand_preact;
  logic        [DeltaBits-1:0] delta_val;
  logic signed [DataWidth-1:0] gate_preact;

  modport source (
    output valid, hidden_new, gated_out, cand_preact, delta_val, gate_preact,
    input  ready
  );

  modport sink (
    input  valid, hidden_new, gated_out, cand_preact, delta_val, gate_preact,
    output ready
  );
endinterface
`default_nettype wire

@@ rtl/drgc_pipe_ctrl.sv @@
`default_nettype none
`include "diag_gated_rnn_cell_forward_defines.svh"
module drgc_pipe_ctrl import drgc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      out_ready,
  output pipe_ctl_t ctl
);

  logic [NumStages-1:0] vld;
  logic [NumStages-1:0] vld_next;
  logic [NumStages-1:0] rdy;
  logic                 in_fire;
  logic                 out_fire;

  // A stage takes new data when it is empty or its successor moves on.
  always_comb begin
    rdy[NumStages-1] = !vld[NumStages-1] || out_ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
    vld_next[0] = rdy[0] ? in_valid : vld[0];
    for (int k = 1; k < NumStages; k++) begin
      vld_next[k] = rdy[k] ? vld[k-1] : vld[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  assign in_fire       = in_valid && rdy[0];
  assign out_fire      = vld[NumStages-1] && out_ready;
  assign ctl.load      = rdy;
  assign ctl.in_ready  = rdy[0];
  assign ctl.out_valid = vld[NumStages-1];

  `DRGC_ASSERT(a_ready_when_drained, !vld[NumStages-1] |-> rdy[0], "input blocked with empty output stage")
  `DRGC_ASSERT(a_full_stall_blocks, (&vld) && !out_ready |-> !rdy[0], "item taken into a full stalled pipeline")
  `DRGC_ASSERT_NEXT(a_occupancy, 1'b1, int'($countones(vld)) == int'($past($countones(vld))) + int'($past(in_fire)) - int'($past(out_fire)), "item lost or duplicated in pipeline")

endmodule
`default_nettype wire

@@ rtl/drgc_lut.sv @@
`default_nettype none
module drgc_lut import drgc_pkg::*; (
  input  logic                        clk,
  input  lut_fn_t                     fn,
  input  lut_ctl_t                    ctl,
  input  logic signed [DataWidth-1:0] raw,
  output logic        [TabValBits-1:0] val
);

  localparam int ProdBits = TabValBits + FrBits + 2;
  localparam logic signed [ProdBits-1:0] Half = ProdBits'(1) <<< (FrBits - 1);

  logic        [DataWidth-1:0]  ofs;
  logic        [IdxBits-1:0]    idx;
  logic        [TabValBits-1:0] t0_next;
  logic        [TabValBits-1:0] t1_next;
  logic        [TabValBits-1:0] t0;
  logic        [TabValBits-1:0] t1;
  logic        [FrBits-1:0]     fr;
  logic signed [TabValBits:0]   diff;
  logic signed [ProdBits-1:0]   prod;
  logic signed [ProdBits-1:0]   res;
  logic        [TabValBits-1:0] val_next;

  assign ofs = {~raw[DataWidth-1], raw[DataWidth-2:0]};
  assign idx = ofs[DataWidth-1 -: IdxBits];

  always_comb begin
    unique case (fn)
      FnTanh: begin
        t0_next = TnhLo[idx];
        t1_next = TnhHi[idx];
      end
      FnSigmoid: begin
        t0_next = SigLo[idx];
        t1_next = SigHi[idx];
      end
      default: begin
        t0_next = SigLo[idx];
        t1_next = SigHi[idx];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.fetch) begin
      t0 <= t0_next;
      t1 <= t1_next;
      fr <= ofs[FrBits-1:0];
    end
  end

  always_comb begin
    diff     = signed'({1'b0, t1}) - signed'({1'b0, t0});
    prod     = diff * signed'({1'b0, fr});
    res      = ProdBits'(signed'({1'b0, t0})) + ((prod + Half) >>> FrBits);
    val_next = res[TabValBits-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.blend) begin
      val <= val_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/drgc_datapath.sv @@
`default_nettype none
module drgc_datapath import drgc_pkg::*; (
  input  logic                 clk,
  input  logic [NumStages-1:0] load,
  input  in_item_t             item,
  output out_item_t            res
);

  localparam int WideBits = 2 * DataWidth + 2;
  localparam int SpBits   = DataWidth + DeltaBits + 1;
  localparam int PaBits   = DeltaBits + 1 + DataWidth;
  localparam int PbBits   = DeltaBits + TabValBits + 2;
  localparam logic signed [WideBits-1:0] RndHalf = WideBits'(1) <<< (FracBits - 1);
  localparam logic signed [WideBits-1:0] SatHi = (WideBits'(1) <<< (DataWidth - 1)) - WideBits'(1);
  localparam logic signed [WideBits-1:0] SatLo = -(WideBits'(1) <<< (DataWidth - 1));
  localparam logic [DeltaBits-1:0] One = DeltaBits'(1) << FracBits;

  function automatic logic signed [WideBits-1:0] rnd_shr(input logic signed [WideBits-1:0] p);
    return (p + RndHalf) >>> FracBits;
  endfunction

  function automatic logic signed [DataWidth-1:0] sat_data(input logic signed [WideBits-1:0] x);
    logic signed [WideBits-1:0] y;
    if (x > SatHi) y = SatHi;
    else if (x < SatLo) y = SatLo;
    else y = x;
    return y[DataWidth-1:0];
  endfunction

  // Stage 1: recurrent products and bias sums.
  logic signed [2*DataWidth-1:0] s1_pv;
  logic signed [2*DataWidth-1:0] s1_pd;
  logic signed [DataWidth:0]     s1_cb;
  logic signed [DataWidth:0]     s1_db;
  logic signed [DataWidth-1:0]   s1_g;
  logic signed [DataWidth-1:0]   s1_hp;

  always_ff @(posedge clk) begin
    if (load[0]) begin
      s1_pv <= item.recur_gain * item.hidden_prev;
      s1_pd <= item.delta_gain * item.hidden_prev;
      s1_cb <= (DataWidth+1)'(item.cand_proj) + (DataWidth+1)'(item.cand_bias);
      s1_db <= (DataWidth+1)'(item.delta_proj) + (DataWidth+1)'(item.delta_bias);
      s1_g  <= sat_data(WideBits'(item.gate_in) + WideBits'(item.gate_bias));
      s1_hp <= item.hidden_prev;
    end
  end

  // Stage 2: candidate and delta preactivations.
  logic signed [DataWidth-1:0] s2_v;
  logic signed [DataWidth-1:0] s2_draw;
  logic signed [DataWidth-1:0] s2_g;
  logic signed [DataWidth-1:0] s2_hp;

  always_ff @(posedge clk) begin
    if (load[1]) begin
      s2_v    <= sat_data(rnd_shr(WideBits'(s1_pv)) + WideBits'(s1_cb));
      s2_draw <= sat_data(rnd_shr(WideBits'(s1_pd)) + WideBits'(s1_db));
      s2_g    <= s1_g;
      s2_hp   <= s1_hp;
    end
  end

  logic [TabValBits-1:0] sg_val;
  logic [TabValBits-1:0] th_val;
  logic [TabValBits-1:0] dl_val;

  drgc_lut u_lut_gate (
    .clk (clk),
    .fn  (FnSigmoid),
    .ctl (lut_ctl_t'{fetch: load[1], blend: load[2]}),
    .raw (s1_g),
    .val (sg_val)
  );

  drgc_lut u_lut_tanh (
    .clk (clk),
    .fn  (FnTanh),
    .ctl (lut_ctl_t'{fetch: load[2], blend: load[3]}),
    .raw (s2_v),
    .val (th_val)
  );

  drgc_lut u_lut_delta (
    .clk (clk),
    .fn  (FnSigmoid),
    .ctl (lut_ctl_t'{fetch: load[2], blend: load[3]}),
    .raw (s2_draw),
    .val (dl_val)
  );

  // Stage 3: table lookups in flight.
  logic signed [DataWidth-1:0] s3_v;
  logic signed [DataWidth-1:0] s3_g;
  logic signed [DataWidth-1:0] s3_hp;

  always_ff @(posedge clk) begin
    if (load[2]) begin
      s3_v  <= s2_v;
      s3_g  <= s2_g;
      s3_hp <= s2_hp;
    end
  end

  // Stage 4: gate times its sigmoid.
  logic signed [SpBits-1:0]    s4_sp;
  logic signed [DataWidth-1:0] s4_v;
  logic signed [DataWidth-1:0] s4_g;
  logic signed [DataWidth-1:0] s4_hp;

  always_ff @(posedge clk) begin
    if (load[3]) begin
      s4_sp <= s3_g * signed'({1'b0, sg_val[DeltaBits-1:0]});
      s4_v  <= s3_v;
      s4_g  <= s3_g;
      s4_hp <= s3_hp;
    end
  end

  // Stage 5: the two terms of the state blend.
  logic        [DeltaBits-1:0]   one_minus;
  logic signed [TabValBits:0]    tv;
  logic signed [WideBits-1:0]    silu_w;
  logic signed [PaBits-1:0]      s5_pa;
  logic signed [PbBits-1:0]      s5_pb;
  logic signed [DataWidth-1:0]   s5_silu;
  logic        [DeltaBits-1:0]   s5_delta;
  logic signed [DataWidth-1:0]   s5_v;
  logic signed [DataWidth-1:0]   s5_g;

  assign one_minus = One - dl_val[DeltaBits-1:0];
  assign tv        = signed'({1'b0, th_val}) - signed'((TabValBits+1)'(One));
  assign silu_w    = rnd_shr(WideBits'(s4_sp));

  always_ff @(posedge clk) begin
    if (load[4]) begin
      s5_pa    <= signed'({1'b0, one_minus}) * s4_hp;
      s5_pb    <= signed'({1'b0, dl_val[DeltaBits-1:0]}) * tv;
      s5_silu  <= silu_w[DataWidth-1:0];
      s5_delta <= dl_val[DeltaBits-1:0];
      s5_v     <= s4_v;
      s5_g     <= s4_g;
    end
  end

  // Stage 6: new hidden element.
  logic signed [DataWidth-1:0] s6_hn;
  logic signed [DataWidth-1:0] s6_silu;
  logic        [DeltaBits-1:0] s6_delta;
  logic signed [DataWidth-1:0] s6_v;
  logic signed [DataWidth-1:0] s6_g;

  always_ff @(posedge clk) begin
    if (load[5]) begin
      s6_hn    <= sat_data(rnd_shr(WideBits'(s5_pa) + WideBits'(s5_pb)));
      s6_silu  <= s5_silu;
      s6_delta <= s5_delta;
      s6_v     <= s5_v;
      s6_g     <= s5_g;
    end
  end

  // Stage 7: gated output product.
  logic signed [2*DataWidth-1:0] s7_pg;
  logic signed [DataWidth-1:0]   s7_hn;
  logic        [DeltaBits-1:0]   s7_delta;
  logic signed [DataWidth-1:0]   s7_v;
  logic signed [DataWidth-1:0]   s7_g;

  always_ff @(posedge clk) begin
    if (load[6]) begin
      s7_pg    <= s6_hn * s6_silu;
      s7_hn    <= s6_hn;
      s7_delta <= s6_delta;
      s7_v     <= s6_v;
      s7_g     <= s6_g;
    end
  end

  // Stage 8: output register.
  always_ff @(posedge clk) begin
    if (load[7]) begin
      res.hidden_new  <= s7_hn;
      res.gated_out   <= sat_data(rnd_shr(WideBits'(s7_pg)));
      res.cand_preact <= s7_v;
      res.delta_val   <= s7_delta;
      res.gate_preact <= s7_g;
    end
  end

endmodule
`default_nettype wire

@@ rtl/diag_gated_rnn_cell_forward.sv @@
`default_nettype none
// Channel  Role    Contents
// din      sink    hidden_prev, projections, gains and biases of one element
// dout     source  hidden_new, gated_out, cand_preact, delta_val, gate_preact
//
// Eight register stages. One item is accepted per cycle while dout is not
// stalled; the gate lookup sits in stages two and three, the candidate and
// delta lookups in stages three and four. Reset clears only the stage valid
// bits; the tables are constants. A stall at dout holds only the stages that
// are full, so empty stages keep taking items until the pipeline is full.
module diag_gated_rnn_cell_forward import drgc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  drgc_in_if.sink    din,
  drgc_out_if.source dout
);

  pipe_ctl_t ctl;
  in_item_t  item;
  out_item_t res;

  drgc_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (din.valid),
    .out_ready (dout.ready),
    .ctl       (ctl)
  );

  always_comb begin
    item.hidden_prev = din.hidden_prev;
    item.cand_proj   = din.cand_proj;
    item.delta_proj  = din.delta_proj;
    item.gate_in     = din.gate_in;
    item.recur_gain  = din.recur_gain;
    item.delta_gain  = din.delta_gain;
    item.cand_bias   = din.cand_bias;
    item.delta_bias  = din.delta_bias;
    item.gate_bias   = din.gate_bias;
  end

  drgc_datapath u_datapath (
    .clk  (clk),
    .load (ctl.load),
    .item (item),
    .res  (res)
  );

  assign din.ready        = ctl.in_ready;
  assign dout.valid       = ctl.out_valid;
  assign dout.hidden_new  = res.hidden_new;
  assign dout.gated_out   = res.gated_out;
  assign dout.cand_preact = res.cand_preact;
  assign dout.delta_val   = res.delta_val;
  assign dout.gate_preact = res.gate_preact;

endmodule
`default_nettype wire

@@ tb/drgc_forward_check.sv @@
`timescale 1ns / 1ps
module drgc_forward_check import drgc_pkg::*; (
  input  logic clk,
  input  logic rst,
  drgc_in_if   din,
  drgc_out_if  dout,
  output int   mismatches,
  output int   awaiting
);

  localparam longint One   = longint'(1) << FracBits;
  localparam longint Unit  = longint'(1) << 30;
  localparam longint Span  = longint'(TabDepth) << FracBits;
  localparam longint Full  = longint'(1) << DataWidth;
  localparam longint DataMax = (longint'(1) << (DataWidth - 1)) - 1;
  localparam longint DataMin = -(longint'(1) << (DataWidth - 1));

  longint    sig_samples [0:TabDepth];
  longint    tnh_samples [0:TabDepth];
  out_item_t results_due [$];

  function automatic longint neg_exp_q30(input longint x);
    longint term;
    longint sum;
    term = Unit;
    sum  = Unit;
    for (int k = 1; k <= 24; k++) begin
      term = ((term * x) >>> 30) / k;
      sum  = (k % 2 == 1) ? sum - term : sum + term;
    end
    return (sum < 0) ? 0 : sum;
  endfunction

  // Rounded 2^s / (1 + exp(-n / Span)) for n >= 0.
  function automatic longint logistic_round(input longint n, input int s);
    longint q;
    longint r;
    longint f;
    longint e;
    longint em1;
    longint den;
    q = n / Span;
    r = n % Span;
    f = 0;
    e = 0;
    if (q < 40) begin
      for (int k = 0; k < 30; k++) begin
        r = r << 1;
        f = f << 1;
        if (r >= Span) begin
          r = r - Span;
          f = f | 1;
        end
      end
      e   = neg_exp_q30(f);
      em1 = neg_exp_q30(Unit);
      for (int k = 0; k < q; k++) begin
        e = (e * em1 + (Unit >>> 1)) >>> 30;
      end
    end
    den = Unit + e;
    return (((longint'(1) << s) << 30) + den / 2) / den;
  endfunction

  function automatic longint clamp_data(input longint x);
    return (x > DataMax) ? DataMax : ((x < DataMin) ? DataMin : x);
  endfunction

  function automatic longint round_frac(input longint p);
    return (p + (longint'(1) << (FracBits - 1))) >>> FracBits;
  endfunction

  function automatic longint interp(input bit tanh_table, input longint raw);
    longint w;
    longint idx;
    longint fr;
    longint lo;
    longint hi;
    w   = (raw - DataMin) * TabDepth;
    idx = w >> DataWidth;
    fr  = w & (Full - 1);
    if (idx >= TabDepth) begin
      idx = TabDepth - 1;
      fr  = Full;
    end
    lo = tanh_table ? tnh_samples[idx] : sig_samples[idx];
    hi = tanh_table ? tnh_samples[idx + 1] : sig_samples[idx + 1];
    return (lo * (Full - fr) + hi * fr + Full / 2) >> DataWidth;
  endfunction

  function automatic out_item_t forward_cell(input in_item_t c);
    out_item_t r;
    longint    hp;
    longint    v;
    longint    draw;
    longint    delta;
    longint    tv;
    longint    hn;
    longint    g;
    longint    silu;
    longint    go;
    hp    = longint'(c.hidden_prev);
    v     = clamp_data(round_frac(longint'(c.recur_gain) * hp) + longint'(c.cand_proj)
                       + longint'(c.cand_bias));
    draw  = clamp_data(longint'(c.delta_proj) + round_frac(longint'(c.delta_gain) * hp)
                       + longint'(c.delta_bias));
    delta = interp(1'b0, draw);
    tv    = interp(1'b1, v) - One;
    hn    = clamp_data(round_frac((One - delta) * hp + delta * tv));
    g     = clamp_data(longint'(c.gate_in) + longint'(c.gate_bias));
    silu  = round_frac(g * interp(1'b0, g));
    go    = clamp_data(round_frac(hn * silu));
    r.hidden_new  = DataWidth'(hn);
    r.gated_out   = DataWidth'(go);
    r.cand_preact = DataWidth'(v);
    r.delta_val   = DeltaBits'(delta);
    r.gate_preact = DataWidth'(g);
    return r;
  endfunction

  initial begin
    longint off;
    longint n;
    mismatches = 0;
    awaiting   = 0;
    for (int i = 0; i <= TabDepth; i++) begin
      off = (longint'(i) << DataWidth) - (longint'(TabDepth) << (DataWidth - 1));
      n   = (off < 0) ? -off : off;
      sig_samples[i] = logistic_round(n, FracBits);
      tnh_samples[i] = logistic_round(2 * n, FracBits + 1);
      if (off < 0) begin
        sig_samples[i] = One - sig_samples[i];
        tnh_samples[i] = 2 * One - tnh_samples[i];
      end
    end
  end

  always @(posedge clk) begin
    in_item_t  taken;
    out_item_t got;
    out_item_t want;
    if (!rst) begin
      if (dout.valid && dout.ready) begin
        got = '{dout.hidden_new, dout.gated_out, dout.cand_preact, dout.delta_val,
                dout.gate_preact};
        if (results_due.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected item at %0t: h=%0d g=%0d v=%0d d=%0d p=%0d", $realtime,
                     got.hidden_new, got.gated_out, got.cand_preact, got.delta_val,
                     got.gate_preact);
          end
          mismatches++;
        end else begin
          want = results_due.pop_front();
          if (got.hidden_new !== want.hidden_new || got.gated_out !== want.gated_out ||
              got.cand_preact !== want.cand_preact || got.delta_val !== want.delta_val ||
              got.gate_preact !== want.gate_preact) begin
            if (mismatches < 10) begin
              $display("mismatch at %0t: expected h=%0d g=%0d v=%0d d=%0d p=%0d", $realtime,
                       want.hidden_new, want.gated_out, want.cand_preact, want.delta_val,
                       want.gate_preact);
              $display("                 actual   h=%0d g=%0d v=%0d d=%0d p=%0d",
                       got.hidden_new, got.gated_out, got.cand_preact, got.delta_val,
                       got.gate_preact);
            end
            mismatches++;
          end
        end
      end
      if (din.valid && din.ready) begin
        taken = '{din.hidden_prev, din.cand_proj, din.delta_proj, din.gate_in,
                  din.recur_gain, din.delta_gain, din.cand_bias, din.delta_bias,
                  din.gate_bias};
        results_due.push_back(forward_cell(taken));
      end
    end
    awaiting = results_due.size();
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb import drgc_pkg::*; ();

  localparam int NumRandom   = 1400;
  localparam int QuietLimit  = 2000;
  localparam int DrainCycles = 32;
  localparam int HoldPeriod  = 900;
  localparam int HoldCycles  = 60;

  typedef logic signed [DataWidth-1:0] sample_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   mismatches;
  int   awaiting;
  int   tx_idle_pct = 33;
  int   rx_idle_pct = 62;
  int   quiet_cycles = 0;

  drgc_in_if  din ();
  drgc_out_if dout ();

  diag_gated_rnn_cell_forward DUT (
    .clk  (clk),
    .rst  (rst),
    .din  (din),
    .dout (dout)
  );

  drgc_forward_check cell_check (
    .clk        (clk),
    .rst        (rst),
    .din        (din),
    .dout       (dout),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  always #2 clk = ~clk;

  function automatic in_item_t cell_of(input int hp, input int cp, input int dp,
                                       input int gp, input int rg, input int dg,
                                       input int cb, input int db, input int gb);
    return '{sample_t'(hp), sample_t'(cp), sample_t'(dp), sample_t'(gp), sample_t'(rg),
             sample_t'(dg), sample_t'(cb), sample_t'(db), sample_t'(gb)};
  endfunction

  function automatic sample_t rand_value(input int style);
    int mode;
    mode = (style >= 8) ? int'($urandom_range(2)) : ((style >= 4) ? 1 : 0);
    case (mode)
      0: return sample_t'($urandom);
      1: return sample_t'(int'($urandom_range(16383)) - 8192);
      default: begin
        case ($urandom_range(7))
          0: return sample_t'(-32768);
          1: return sample_t'(32767);
          2: return sample_t'(0);
          3: return sample_t'(1);
          4: return sample_t'(-1);
          5: return sample_t'(4096);
          6: return sample_t'(-4096);
          default: return sample_t'(2048);
        endcase
      end
    endcase
  endfunction

  function automatic in_item_t random_cell();
    int style;
    style = $urandom_range(9);
    return '{rand_value(style), rand_value(style), rand_value(style), rand_value(style),
             rand_value(style), rand_value(style), rand_value(style), rand_value(style),
             rand_value(style)};
  endfunction

  task automatic send_cell(input in_item_t c);
    while ($urandom_range(99) < tx_idle_pct) begin
      din.valid <= 1'b0;
      @(posedge clk);
    end
    din.valid <= 1'b1;
    {din.hidden_prev, din.cand_proj, din.delta_proj, din.gate_in, din.recur_gain,
     din.delta_gain, din.cand_bias, din.delta_bias, din.gate_bias} <= c;
    @(posedge clk);
    while (!din.ready) @(posedge clk);
  endtask

  initial begin
    int tick;
    tick = 0;
    dout.ready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (tick % HoldPeriod == HoldPeriod / 2) begin
        dout.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        dout.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (din.valid && din.ready) || (dout.valid && dout.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    din.valid <= 1'b0;
    {din.hidden_prev, din.cand_proj, din.delta_proj, din.gate_in, din.recur_gain,
     din.delta_gain, din.cand_bias, din.delta_bias, din.gate_bias} <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_cell(cell_of(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_cell(cell_of(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                      -32768));
    send_cell(cell_of(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_cell(cell_of(32767, 32767, 0, 0, 32767, 0, 32767, 0, 0));
    send_cell(cell_of(32767, -32768, 0, 0, -32768, 0, -32768, 0, 0));
    send_cell(cell_of(32767, 0, 32767, 0, 0, 32767, 0, 32767, 0));
    send_cell(cell_of(32767, 0, -32768, 0, 0, -32768, 0, -32768, 0));
    send_cell(cell_of(4096, 0, 0, 32767, 0, 0, 0, 0, 32767));
    send_cell(cell_of(4096, 0, 0, -32768, 0, 0, 0, 0, -32768));
    // Products that land exactly halfway between two codes.
    send_cell(cell_of(1, 0, 0, 0, -2048, -2048, 0, 0, 0));
    send_cell(cell_of(1, 0, 0, 0, 2048, 2048, 0, 0, 0));
    send_cell(cell_of(-1, 0, 0, 0, 2048, 2048, 0, 0, 0));
    // Lookups at both ends of the tables, on a sample and between samples.
    send_cell(cell_of(0, 32767, 32767, 32767, 0, 0, 0, 0, 0));
    send_cell(cell_of(0, -32768, -32768, -32768, 0, 0, 0, 0, 0));
    send_cell(cell_of(4096, 256, -256, 512, 0, 0, 0, 0, 0));
    send_cell(cell_of(-4096, 128, 384, -128, 0, 0, 0, 0, 0));
    send_cell(cell_of(4096, 0, 0, -4096, 0, 0, 0, 0, 0));
    // Hidden value kept whole and scaled into saturation by the gate, or replaced and gated off.
    send_cell(cell_of(32767, 0, -32768, 32767, 0, 0, 0, 0, 0));
    send_cell(cell_of(-32768, 0, -32768, 32767, 0, 0, 0, 0, 0));
    send_cell(cell_of(-32768, 0, 32767, -32768, 0, 0, 0, 0, 0));

    for (int i = 0; i < NumRandom; i++) begin
      if (i == NumRandom / 3) begin
        tx_idle_pct = 62;
        rx_idle_pct = 33;
      end else if (i == 2 * NumRandom / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      send_cell(random_cell());
    end
    din.valid <= 1'b0;

    while (awaiting != 0) @(negedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && awaiting == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
